[hdl/bsc_pkg.sv]
package bsc_pkg;

  // Field widths of the transactions and the configuration port
  localparam int RawW  = 19;
  localparam int ValW  = 21;
  localparam int CfgW  = 48;
  localparam int CfgIdxW = 3;

  // Datapath widths: shared multiplier operands, wide intermediates, divider
  localparam int MulW  = 33;
  localparam int WideW = 64;
  localparam int DivW  = 32;

  // Constants of the compensation formulas
  localparam logic signed [WideW-1:0] TempOffset  = 64'sd4000;
  localparam logic signed [WideW-1:0] TempRound   = 64'sd8;
  localparam logic signed [WideW-1:0] B4Offset    = 64'sd32768;
  localparam logic signed [WideW-1:0] QuarterRnd  = 64'sd2;
  localparam logic signed [WideW-1:0] PressOffset = 64'sd3791;
  localparam logic signed [MulW-1:0]  PressCoefA  = 33'sd3038;
  localparam logic signed [MulW-1:0]  PressCoefB  = -33'sd7357;
  localparam logic [15:0]             PressScale  = 16'd50000;
  localparam logic signed [WideW-1:0] ValMax      = 64'sd1048575;
  localparam logic signed [WideW-1:0] ValMin      = -64'sd1048576;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_AC123 = 3'd0,
    CFG_AC456 = 3'd1,
    CFG_B12   = 3'd2,
    CFG_MCMD  = 3'd3,
    CFG_OSS   = 3'd4
  } cfg_idx_e;

  // Result error codes
  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_DIV0   = 2'd1,
    ERR_NOTEMP = 2'd2
  } err_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV_WAIT,
    ST_DONE
  } ctrl_state_e;

  // Datapath step codes
  typedef enum logic [5:0] {
    OP_NONE,
    OP_DISPATCH,
    OP_T_M0, OP_T_M1, OP_T_M2, OP_T_M3, OP_T_M4,
    OP_P_M0, OP_P_M1, OP_P_M2, OP_P_M3, OP_P_M4, OP_P_M5, OP_P_M6,
    OP_P_M7, OP_P_M8, OP_P_M9, OP_P_M10, OP_P_M11, OP_P_M12, OP_P_M13,
    OP_P_DIV,
    OP_P_M14, OP_P_M15, OP_P_M16, OP_P_M17, OP_P_M18, OP_P_M19, OP_P_M20,
    OP_P_M21
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load_in;
    logic div_start;
    logic load_out;
  } bsc_cmd_t;

  typedef struct packed {
    logic act;
    logic temp_seen;
    logic den_zero;
    logic b4_zero;
    logic div_done;
  } bsc_sts_t;

  // Clamp a wide signed value to the result range
  function automatic logic signed [ValW-1:0] sat_val(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] r;
    if (v > ValMax) begin
      r = ValMax;
    end else if (v < ValMin) begin
      r = ValMin;
    end else begin
      r = v;
    end
    return r[ValW-1:0];
  endfunction

endpackage

[hdl/bsc_if.sv]
interface bsc_in_if;
  import bsc_pkg::*;
  logic            valid;
  logic            ready;
  logic            action;
  logic [RawW-1:0] raw_value;
  modport source (output valid, output action, output raw_value, input ready);
  modport sink (input valid, input action, input raw_value, output ready);
endinterface

interface bsc_out_if;
  import bsc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic signed [ValW-1:0] value;
  logic [1:0]             error;
  modport source (output valid, output kind, output value, output error, input ready);
  modport sink (input valid, input kind, input value, input error, output ready);
endinterface

[hdl/bsc_div.sv]
module bsc_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [bsc_pkg::DivW-1:0] dividend_i,
  input  logic [bsc_pkg::DivW-1:0] divisor_i,
  output logic                     done_o,
  output logic [bsc_pkg::DivW-1:0] quotient_o
);
  import bsc_pkg::*;

  localparam int CntW = $clog2(DivW + 1);

  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [DivW-1:0] quo_q;
  logic [DivW-1:0] rem_q;
  logic [DivW-1:0] dsr_q;
  logic [DivW:0]   rem_sh;
  logic [DivW:0]   rem_nxt;
  logic            ge;

  // One quotient bit per cycle, restoring form
  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign ge      = rem_sh >= {1'b0, dsr_q};
  assign rem_nxt = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(DivW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DivW-2:0], ge};
      rem_q <= rem_nxt[DivW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[hdl/bsc_dp.sv]
module bsc_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bsc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [bsc_pkg::CfgW-1:0]        cfg_data_i,
  input  logic                            action_i,
  input  logic [bsc_pkg::RawW-1:0]        raw_value_i,
  input  bsc_pkg::bsc_cmd_t               cmd_i,
  output bsc_pkg::bsc_sts_t               sts_o,
  output logic                            kind_o,
  output logic signed [bsc_pkg::ValW-1:0] value_o,
  output logic [1:0]                      error_o
);
  import bsc_pkg::*;

  // Configuration and persistent state
  logic [47:0]        cal0_q;
  logic [47:0]        cal1_q;
  logic [31:0]        cal2_q;
  logic [31:0]        cal3_q;
  logic [1:0]         oss_q;
  logic signed [31:0] tc_q;
  logic               seen_q;

  // Working registers
  logic                     act_q;
  logic [RawW-1:0]          raw_q;
  logic signed [2*MulW-1:0] prod_q;
  logic signed [WideW-1:0]  acc_q;
  logic signed [WideW-1:0]  sq_q;
  logic signed [WideW-1:0]  wa_q;
  logic signed [WideW-1:0]  x3_q;
  logic signed [WideW-1:0]  b3_q;
  logic signed [WideW-1:0]  tmp_q;
  logic signed [WideW-1:0]  den_q;
  logic [31:0]              t_q;
  logic [31:0]              b4_q;
  logic [31:0]              b7_q;
  logic signed [31:0]       p_q;
  logic                     neg_q;
  logic signed [ValW-1:0]   res_value_q;
  err_e                     res_err_q;
  logic                     out_kind_q;
  logic signed [ValW-1:0]   out_value_q;
  err_e                     out_err_q;

  // Calibration fields
  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;
  assign ac1 = $signed(cal0_q[47:32]);
  assign ac2 = $signed(cal0_q[31:16]);
  assign ac3 = $signed(cal0_q[15:0]);
  assign ac4 = cal1_q[47:32];
  assign ac5 = cal1_q[31:16];
  assign ac6 = cal1_q[15:0];
  assign b1  = $signed(cal2_q[31:16]);
  assign b2  = $signed(cal2_q[15:0]);
  assign mc  = $signed(cal3_q[31:16]);
  assign md  = $signed(cal3_q[15:0]);

  // Derived values
  logic signed [MulW-1:0]   mul_a, mul_b, sq_lo, sq_hi, p_sh;
  logic signed [2*MulW-1:0] prod_d;
  logic signed [WideW-1:0]  prod_w, b3_w, t_w, diff_w, num_w, num_mag, den_mag;
  logic signed [WideW-1:0]  quo_w, quo_s, tsum;
  logic [15:0]              scale;
  logic [DivW-1:0]          div_a, div_b, quo;
  logic [31:0]              pu;
  logic                     div_done;

  assign prod_w  = WideW'(prod_q);
  assign sq_lo   = MulW'($signed({1'b0, sq_q[15:0]}));
  assign sq_hi   = $signed(sq_q[48:16]);
  assign p_sh    = MulW'(p_q >>> 8);
  assign scale   = PressScale >> oss_q;
  assign b3_w    = ((((WideW'(ac1) <<< 2) + x3_q) <<< oss_q) + QuarterRnd) >>> 2;
  assign t_w     = ((tmp_q + QuarterRnd) >>> 2) + B4Offset;
  assign diff_w  = WideW'($signed({1'b0, raw_q})) - b3_q;
  assign num_w   = WideW'(mc) <<< 11;
  assign num_mag = num_w[WideW-1] ? -num_w : num_w;
  assign den_mag = den_q[WideW-1] ? -den_q : den_q;
  assign quo_w   = WideW'($signed({1'b0, quo}));
  assign quo_s   = neg_q ? -quo_w : quo_w;
  assign tsum    = tmp_q + quo_s;
  assign pu      = b7_q[31] ? {quo[30:0], 1'b0} : quo;

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_T_M0: begin
        mul_a = MulW'($signed({1'b0, raw_q})) - MulW'($signed({1'b0, ac6}));
        mul_b = MulW'($signed({1'b0, ac5}));
      end
      OP_P_M0: begin
        mul_a = MulW'(tc_q);
        mul_b = MulW'(tc_q);
      end
      OP_P_M2: begin
        mul_a = MulW'(b2);
        mul_b = sq_lo;
      end
      OP_P_M3: begin
        mul_a = MulW'(b2);
        mul_b = sq_hi;
      end
      OP_P_M4: begin
        mul_a = MulW'(ac2);
        mul_b = MulW'(tc_q);
      end
      OP_P_M5: begin
        mul_a = MulW'(ac3);
        mul_b = MulW'(tc_q);
      end
      OP_P_M6: begin
        mul_a = MulW'(b1);
        mul_b = sq_lo;
      end
      OP_P_M7: begin
        mul_a = MulW'(b1);
        mul_b = sq_hi;
      end
      OP_P_M10: begin
        mul_a = MulW'($signed({1'b0, ac4}));
        mul_b = $signed({1'b0, t_q});
      end
      OP_P_M12: begin
        mul_a = $signed({1'b0, diff_w[31:0]});
        mul_b = MulW'($signed({1'b0, scale}));
      end
      OP_P_M15: begin
        mul_a = p_sh;
        mul_b = p_sh;
      end
      OP_P_M17: begin
        mul_a = PressCoefA;
        mul_b = sq_lo;
      end
      OP_P_M18: begin
        mul_a = PressCoefA;
        mul_b = sq_hi;
      end
      OP_P_M19: begin
        mul_a = PressCoefB;
        mul_b = MulW'(p_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Divider operands: signed temperature quotient or unsigned pressure quotient
  always_comb begin
    if (cmd_i.op == OP_T_M3) begin
      div_a = num_mag[DivW-1:0];
      div_b = den_mag[DivW-1:0];
    end else begin
      div_a = b7_q[31] ? b7_q : {b7_q[30:0], 1'b0};
      div_b = b4_q;
    end
  end

  bsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // Configuration registers and the stored temperature term
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal0_q <= '0;
      cal1_q <= '0;
      cal2_q <= '0;
      cal3_q <= '0;
      oss_q  <= '0;
      tc_q   <= '0;
      seen_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_AC123: cal0_q <= cfg_data_i;
          CFG_AC456: cal1_q <= cfg_data_i;
          CFG_B12:   cal2_q <= cfg_data_i[31:0];
          CFG_MCMD:  cal3_q <= cfg_data_i[31:0];
          CFG_OSS:   oss_q  <= cfg_data_i[1:0];
          default:   ;
        endcase
      end
      if (cmd_i.op == OP_T_M4) begin
        tc_q   <= 32'(tsum - TempOffset);
        seen_q <= 1'b1;
      end
    end
  end

  // Step registers of the compensation sequence
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load_in) begin
      act_q <= action_i;
      raw_q <= raw_value_i;
    end
    if (cmd_i.load_out) begin
      out_kind_q  <= act_q;
      out_value_q <= res_value_q;
      out_err_q   <= res_err_q;
    end
    case (cmd_i.op)
      OP_DISPATCH: begin
        res_value_q <= '0;
        res_err_q   <= ERR_NOTEMP;
      end
      OP_T_M1: tmp_q <= prod_w >>> 15;
      OP_T_M2: den_q <= tmp_q + WideW'(md);
      OP_T_M3: begin
        if (den_q == '0) begin
          res_value_q <= '0;
          res_err_q   <= ERR_DIV0;
        end
        neg_q <= num_w[WideW-1] ^ den_q[WideW-1];
      end
      OP_T_M4: begin
        res_value_q <= sat_val((tsum + TempRound) >>> 4);
        res_err_q   <= ERR_OK;
      end
      OP_P_M1:  sq_q  <= prod_w >>> 12;
      OP_P_M3:  acc_q <= prod_w;
      OP_P_M4:  wa_q  <= (acc_q + (prod_w <<< 16)) >>> 11;
      OP_P_M5:  x3_q  <= wa_q + (prod_w >>> 11);
      OP_P_M6: begin
        b3_q <= b3_w;
        wa_q <= prod_w >>> 13;
      end
      OP_P_M7:  acc_q <= prod_w;
      OP_P_M8:  tmp_q <= wa_q + ((acc_q + (prod_w <<< 16)) >>> 16);
      OP_P_M9:  t_q   <= t_w[31:0];
      OP_P_M11: b4_q  <= prod_q[46:15];
      OP_P_M12: begin
        if (b4_q == '0) begin
          res_value_q <= '0;
          res_err_q   <= ERR_DIV0;
        end
      end
      OP_P_M13: b7_q  <= prod_q[31:0];
      OP_P_M14: p_q   <= $signed(pu);
      OP_P_M16: sq_q  <= prod_w;
      OP_P_M18: acc_q <= prod_w;
      OP_P_M19: wa_q  <= (acc_q + (prod_w <<< 16)) >>> 16;
      OP_P_M20: tmp_q <= wa_q + (prod_w >>> 16) + PressOffset;
      OP_P_M21: begin
        res_value_q <= sat_val(WideW'(p_q) + (tmp_q >>> 4));
        res_err_q   <= ERR_OK;
      end
      default: ;
    endcase
  end

  assign sts_o.act       = act_q;
  assign sts_o.temp_seen = seen_q;
  assign sts_o.den_zero  = (den_q == '0);
  assign sts_o.b4_zero   = (b4_q == '0);
  assign sts_o.div_done  = div_done;

  assign kind_o  = out_kind_q;
  assign value_o = out_value_q;
  assign error_o = out_err_q;

endmodule

[hdl/bsc_ctrl.sv]
module bsc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bsc_pkg::bsc_cmd_t  cmd_o,
  input  bsc_pkg::bsc_sts_t  sts_i
);
  import bsc_pkg::*;

  ctrl_state_e state_q, state_d;
  op_e         op_q, op_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Step sequencing and handshake control
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o       = '{op: OP_NONE, load_in: 1'b0, div_start: 1'b0, load_out: 1'b0};
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          op_d          = OP_DISPATCH;
          state_d       = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.op = op_q;
        unique case (op_q)
          OP_DISPATCH: begin
            if (!sts_i.act) begin
              op_d = OP_T_M0;
            end else if (sts_i.temp_seen) begin
              op_d = OP_P_M0;
            end else begin
              op_d    = OP_NONE;
              state_d = ST_DONE;
            end
          end
          OP_T_M0: op_d = OP_T_M1;
          OP_T_M1: op_d = OP_T_M2;
          OP_T_M2: op_d = OP_T_M3;
          OP_T_M3: begin
            if (sts_i.den_zero) begin
              op_d    = OP_NONE;
              state_d = ST_DONE;
            end else begin
              cmd_o.div_start = 1'b1;
              op_d            = OP_T_M4;
              state_d         = ST_DIV_WAIT;
            end
          end
          OP_P_M0:  op_d = OP_P_M1;
          OP_P_M1:  op_d = OP_P_M2;
          OP_P_M2:  op_d = OP_P_M3;
          OP_P_M3:  op_d = OP_P_M4;
          OP_P_M4:  op_d = OP_P_M5;
          OP_P_M5:  op_d = OP_P_M6;
          OP_P_M6:  op_d = OP_P_M7;
          OP_P_M7:  op_d = OP_P_M8;
          OP_P_M8:  op_d = OP_P_M9;
          OP_P_M9:  op_d = OP_P_M10;
          OP_P_M10: op_d = OP_P_M11;
          OP_P_M11: op_d = OP_P_M12;
          OP_P_M12: begin
            if (sts_i.b4_zero) begin
              op_d    = OP_NONE;
              state_d = ST_DONE;
            end else begin
              op_d = OP_P_M13;
            end
          end
          OP_P_M13: op_d = OP_P_DIV;
          OP_P_DIV: begin
            cmd_o.div_start = 1'b1;
            op_d            = OP_P_M14;
            state_d         = ST_DIV_WAIT;
          end
          OP_P_M14: op_d = OP_P_M15;
          OP_P_M15: op_d = OP_P_M16;
          OP_P_M16: op_d = OP_P_M17;
          OP_P_M17: op_d = OP_P_M18;
          OP_P_M18: op_d = OP_P_M19;
          OP_P_M19: op_d = OP_P_M20;
          OP_P_M20: op_d = OP_P_M21;
          default: begin
            op_d    = OP_NONE;
            state_d = ST_DONE;
          end
        endcase
      end
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_STEP;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/baro_sensor_compensation_top.sv]
// Barometric sensor compensation.
// The input channel carries transactions of a raw temperature (action 0) or a
// raw pressure (action 1) reading; the output channel returns one transaction
// per input with the kind, the compensated value and an error code.
// Calibration words and the oversampling setting are written through the
// configuration port; the user must do so only while the block is idle, as
// the block itself does not enforce it. Writes to unknown indexes are ignored.
// A good transaction runs the whole step sequence of the single shared 33x33
// multiplier and the serial divider; flagged results come out earlier.
// One transaction is in work at a time; the next is taken only after the
// previous result has moved into the output register.
// The output register holds a finished result while the receiver stalls; a
// new transaction may be accepted meanwhile, and its result waits in the
// datapath until the output register is free.
// Reset clears the configuration, the stored temperature term and all
// handshake state; a pressure reading before any good temperature reports the
// no-temperature error.
module baro_sensor_compensation_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bsc_in_if.sink                         in_i,
  bsc_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [bsc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bsc_pkg::CfgW-1:0]       cfg_data_i
);
  import bsc_pkg::*;

  bsc_cmd_t cmd;
  bsc_sts_t sts;

  bsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bsc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .action_i    (in_i.action),
    .raw_value_i (in_i.raw_value),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_o      (out_o.kind),
    .value_o     (out_o.value),
    .error_o     (out_o.error)
  );

`ifndef SYNTHESIS
  // An accepted transaction closes the input until its result is staged.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while a transaction is in work");

  // A result is never staged over one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_o.valid || out_o.ready))
    else $error("pending result overwritten");

  // The divider is only started from a step state.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> (cmd.op == OP_T_M3 || cmd.op == OP_P_DIV))
    else $error("divider started outside its step");
`endif

endmodule
